FILE: hdl/dys_pkg.sv
// Package with the shared types, constants and date rules of the date table.
`default_nettype none

package dys_pkg;

	localparam int MAX_ENTRIES = 512;
	localparam int ADDR_W      = 9;
	localparam int CNT_W       = 10;

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_BAD_DATE  = 3'd1;
	localparam logic [2:0] STS_DUPLICATE = 3'd2;
	localparam logic [2:0] STS_FULL      = 3'd3;
	localparam logic [2:0] STS_RANGE     = 3'd4;

	typedef struct packed {
		logic [3:0] month;
		logic [4:0] day;
	} date_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [4:0]       day_in;
		logic [3:0]       month_in;
		logic [ADDR_W-1:0] position;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [4:0]       day_out;
		logic [3:0]       month_out;
		logic [CNT_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] raddr;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		date_t             wdata;
	} mem_req_t;

	function automatic logic [4:0] month_len(input logic [3:0] month);
		logic [4:0] len;
		case (month)
			4'd2: len = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic date_ok(input logic [4:0] day, input logic [3:0] month);
		logic ok;
		ok = (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1) && (day <= month_len(month));
		return ok;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/dys_req_if.sv
// Request channel interface of the date table.
`default_nettype none

interface dys_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [4:0]  day_in;
	logic [3:0]  month_in;
	logic [8:0]  position;

	modport source (output valid, action, day_in, month_in, position, input ready);
	modport sink (input valid, action, day_in, month_in, position, output ready);
endinterface

`default_nettype wire

FILE: hdl/dys_rsp_if.sv
// Response channel interface of the date table.
`default_nettype none

interface dys_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [4:0]  day_out;
	logic [3:0]  month_out;
	logic [9:0]  entry_count;

	modport source (output valid, status, day_out, month_out, entry_count, input ready);
	modport sink (input valid, status, day_out, month_out, entry_count, output ready);
endinterface

`default_nettype wire

FILE: hdl/dys_store.sv
// Date memory with one write port and one registered read port.
`default_nettype none

module dys_store (
	input  logic              clk,
	input  dys_pkg::mem_req_t mem_req,
	output dys_pkg::date_t    rd_data
);
	import dys_pkg::*;

	date_t mem_q [MAX_ENTRIES];
	date_t rdata_q;

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem_q[mem_req.waddr] <= mem_req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_req.re) begin
			rdata_q <= mem_q[mem_req.raddr];
		end
	end

	assign rd_data = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/dys_ctrl.sv
// Sequencer that walks the date memory for scans, compaction and reads.
`default_nettype none

module dys_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  dys_pkg::req_t     req_data,
	input  logic              slot_free,
	input  dys_pkg::date_t    rd_data,
	output dys_pkg::mem_req_t mem_req,
	output logic              idle,
	output logic              done,
	output dys_pkg::rsp_t     rsp_data
);
	import dys_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_SHIFT = 5'b00100,
		S_READ  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t            state_q;
	date_t             key_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] wa_q;
	logic              pend_q;
	logic [2:0]        status_q;
	logic [4:0]        day_q;
	logic [3:0]        month_q;

	logic             more;
	logic             match;
	logic [CNT_W-1:0] pos_ext;
	logic             pos_bad;
	logic [CNT_W-1:0] ptr_dec;

	assign more    = ptr_q < count_q;
	assign match   = pend_q && (rd_data == key_q);
	assign pos_ext = {1'b0, req_data.position};
	assign pos_bad = pos_ext >= count_q;
	assign ptr_dec = ptr_q - CNT_W'(1);

	always_comb begin
		mem_req = '0;
		case (state_q)
			S_IDLE: begin
				mem_req.re    = in_fire && (req_data.action == ACT_READ);
				mem_req.raddr = req_data.position;
			end
			S_SCAN: begin
				mem_req.re    = more && !match;
				mem_req.raddr = ptr_q[ADDR_W-1:0];
				mem_req.we    = !match && !more && !pend_q && (count_q != CNT_W'(MAX_ENTRIES));
				mem_req.waddr = count_q[ADDR_W-1:0];
				mem_req.wdata = key_q;
			end
			S_SHIFT: begin
				mem_req.re    = more;
				mem_req.raddr = ptr_q[ADDR_W-1:0];
				mem_req.we    = pend_q;
				mem_req.waddr = wa_q;
				mem_req.wdata = rd_data;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						pend_q <= 1'b0;
						case (req_data.action)
							ACT_ADD: begin
								if (date_ok(req_data.day_in, req_data.month_in)) begin
									state_q <= S_SCAN;
								end else begin
									state_q <= S_DONE;
								end
							end
							ACT_REMOVE: begin
								if (pos_bad) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_SHIFT;
								end
							end
							ACT_READ: begin
								if (pos_bad) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_READ;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (match) begin
						state_q <= S_DONE;
					end else if (more) begin
						pend_q <= 1'b1;
					end else if (pend_q) begin
						pend_q <= 1'b0;
					end else begin
						if (count_q != CNT_W'(MAX_ENTRIES)) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= S_DONE;
					end
				end
				S_SHIFT: begin
					pend_q <= more;
					if (!more && !pend_q) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					key_q    <= {req_data.month_in, req_data.day_in};
					day_q    <= '0;
					month_q  <= '0;
					status_q <= STS_OK;
					ptr_q    <= '0;
					case (req_data.action)
						ACT_ADD: begin
							if (!date_ok(req_data.day_in, req_data.month_in)) begin
								status_q <= STS_BAD_DATE;
							end
						end
						ACT_REMOVE: begin
							ptr_q <= pos_ext + CNT_W'(1);
							if (pos_bad) begin
								status_q <= STS_RANGE;
							end
						end
						ACT_READ: begin
							if (pos_bad) begin
								status_q <= STS_RANGE;
							end
						end
						default: begin
							status_q <= STS_OK;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (match) begin
					status_q <= STS_DUPLICATE;
				end else if (more) begin
					ptr_q <= ptr_q + CNT_W'(1);
				end else if (!pend_q && (count_q == CNT_W'(MAX_ENTRIES))) begin
					status_q <= STS_FULL;
				end
			end
			S_SHIFT: begin
				if (more) begin
					ptr_q <= ptr_q + CNT_W'(1);
					wa_q  <= ptr_dec[ADDR_W-1:0];
				end
			end
			S_READ: begin
				day_q   <= rd_data.day;
				month_q <= rd_data.month;
			end
			default: begin
				day_q <= day_q;
			end
		endcase
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_DONE);

	always_comb begin
		rsp_data.status      = status_q;
		rsp_data.day_out     = day_q;
		rsp_data.month_out   = month_q;
		rsp_data.entry_count = count_q;
	end

endmodule

`default_nettype wire

FILE: hdl/day_of_year_set_table_unit.sv
// Top level of the ordered date table with request and response channels.
//
// The block keeps up to 512 distinct dates in one single-port-read memory and
// takes one request beat at a time, giving one response beat for each. An add
// with a valid date reads the stored entries in turn, one per cycle, against a
// single comparator and appends if none matches and the table is not full; a
// remove reads and rewrites each later entry once. The response sits in an
// output register, so a finished beat may wait there while the next request
// is already being worked on. The memory needs no clearing after reset.
`default_nettype none

module day_of_year_set_table_unit (
	input logic     clk,
	input logic     arst_n,
	dys_req_if.sink   req,
	dys_rsp_if.source rsp
);
	import dys_pkg::*;

	req_t     req_data;
	rsp_t     ctrl_rsp;
	rsp_t     rsp_q;
	logic     rsp_vld_q;
	mem_req_t mem_req;
	date_t    rd_data;
	logic     idle;
	logic     done;
	logic     slot_free;
	logic     in_fire;

	assign req_data  = '{action: req.action, day_in: req.day_in,
	                     month_in: req.month_in, position: req.position};
	assign req.ready = idle;
	assign in_fire   = req.valid && idle;
	assign slot_free = !rsp_vld_q || rsp.ready;

	dys_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.req_data (req_data),
		.slot_free(slot_free),
		.rd_data  (rd_data),
		.mem_req  (mem_req),
		.idle     (idle),
		.done     (done),
		.rsp_data (ctrl_rsp)
	);

	dys_store u_store (
		.clk    (clk),
		.mem_req(mem_req),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (done && slot_free) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && slot_free) begin
			rsp_q <= ctrl_rsp;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.day_out     = rsp_q.day_out;
	assign rsp.month_out   = rsp_q.month_out;
	assign rsp.entry_count = rsp_q.entry_count;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.entry_count <= CNT_W'(MAX_ENTRIES)))
		else $error("entry count beyond table size");

	a_error_no_date: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != STS_OK)) |-> (rsp.day_out == 5'd0 && rsp.month_out == 4'd0))
		else $error("date returned with an error status");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while previous one still in progress");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		idle |-> !mem_req.we)
		else $error("memory written while idle");

endmodule

`default_nettype wire
